FILE: rtl/udbn_pkg.sv
// Shared constants and types for the upload deadline byte need block.
// Used by udbn_div and upload_deadline_byte_need; depends on nothing.
package udbn_pkg;

   localparam int SIZE_W  = 24;
   localparam int MS_W    = 32;
   localparam int WIN_W   = 17;
   localparam int PROD_W  = 41;
   localparam int DIVX_W  = 38;
   localparam int QUOT_W  = 26;
   localparam int RECIP_SHIFT = 38;
   localparam int SPLIT_W = 19;
   localparam int PP_W    = SPLIT_W + QUOT_W;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 32;

   localparam logic [WIN_W-1:0] DEADLINE_FAST_MS = WIN_W'(45000);
   localparam logic [WIN_W-1:0] DEADLINE_SLOW_MS = WIN_W'(90000);
   localparam logic [MS_W-1:0]  KEEPALIVE_GAP_MS = MS_W'(20000);

   // both deadlines are 5625 times a power of two
   localparam logic [12:0] DIV_BASE = 13'd5625;
   localparam logic [QUOT_W-1:0] RECIP =
      QUOT_W'((64'd1 << RECIP_SHIFT) / 64'd5625);

   typedef struct packed {
      logic              valid;
      logic              active;
      logic              acc;
      logic              past;
      logic              idle_gt;
      logic              on_pace;
      logic [SIZE_W-1:0] left;
   } side_type;

endpackage

FILE: rtl/upload_deadline_byte_need.sv
// Top level of the upload deadline byte need block.
// Depends on udbn_pkg and udbn_div.
//
// One request transfer carries a snapshot of a connection's send state; one
// response transfer returns the least number of bytes to send now so that
// the pending standard packet meets its deadline (45000 ms accelerated,
// 90000 ms otherwise), plus the accelerate flag to store back.
// Channels: req_* stream in, rsp_* stream out, no side fields.
// Throughput: one transfer per cycle unless the output stalls; the pipeline has seven
// register stages (decode, deadline product, pace compare with reciprocal
// partial products, quotient estimate, back product, correction, result).
// The divide by the deadline is a reciprocal multiply with one correction.
// Stall: when rsp_tready is low with a response waiting, the whole
// pipeline holds and req_tready drops in the same cycle; nothing is lost
// or repeated.
// Reset: clears every stage valid bit; no clearing pass, ready at once.
module upload_deadline_byte_need (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // connected, standard_in_progress, standard_queue_nonempty,
   // control_queue_nonempty, accelerate_in, bytes_left_current[24],
   // size_current[24], size_next_queued[24], ms_since_finished[32],
   // ms_since_send_call[32], zero fill
   input  logic [udbn_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // needed_bytes[24], accelerate_out, zero fill
   output logic [udbn_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic advance;

   logic                           connected, busy, stdq, ctlq, acc_req;
   logic [udbn_pkg::SIZE_W-1:0]    left_cur, size_cur, size_next;
   logic [udbn_pkg::MS_W-1:0]      elapsed, idle;
   logic [udbn_pkg::WIN_W-1:0]     window;

   logic                           s1_valid_ff, s1_active_ff, s1_acc_ff, s1_fast_ff;
   logic                           s1_past_ff, s1_idle_ff;
   logic                           s1_active_in, s1_acc_in, s1_past_in, s1_idle_in;
   logic [udbn_pkg::SIZE_W-1:0]    s1_left_ff, s1_total_ff, s1_left_in, s1_total_in;
   logic [udbn_pkg::WIN_W-1:0]     s1_remain_ff, s1_remain_in;

   logic                           s2_valid_ff, s2_active_ff, s2_acc_ff, s2_fast_ff;
   logic                           s2_past_ff, s2_idle_ff;
   logic [udbn_pkg::SIZE_W-1:0]    s2_left_ff;
   logic [udbn_pkg::PROD_W-1:0]    s2_prod_ff, s2_wl_ff, s2_prod_in, s2_wl_in;
   logic [udbn_pkg::WIN_W-1:0]     s1_window;

   logic [udbn_pkg::DIVX_W-1:0]    div_x;
   logic [udbn_pkg::QUOT_W-1:0]    allow;

   udbn_pkg::side_type             s3_in, s3_ff, s4_ff, s5_ff, s6_ff;

   logic                           out_valid_ff;
   logic [udbn_pkg::SIZE_W-1:0]    need_ff, need_in;
   logic                           acc_out_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // stage 1: decode the snapshot
   always_comb begin
      connected = req_tdata[0];
      busy      = req_tdata[1];
      stdq      = req_tdata[2];
      ctlq      = req_tdata[3];
      acc_req   = req_tdata[4];
      left_cur  = req_tdata[28:5];
      size_cur  = req_tdata[52:29];
      size_next = req_tdata[76:53];
      elapsed   = req_tdata[108:77];
      idle      = req_tdata[140:109];

      s1_active_in = connected && (busy || stdq);
      s1_acc_in    = acc_req || (s1_active_in && busy && ctlq);
      window       = s1_acc_in ? udbn_pkg::DEADLINE_FAST_MS : udbn_pkg::DEADLINE_SLOW_MS;
      s1_past_in   = elapsed >= udbn_pkg::MS_W'(window);
      s1_remain_in = window - elapsed[udbn_pkg::WIN_W-1:0];
      s1_idle_in   = idle > udbn_pkg::KEEPALIVE_GAP_MS;
      s1_left_in   = busy ? left_cur : size_next;
      s1_total_in  = busy ? size_cur : size_next;
   end

   // stage 2: allowance product and deadline-scaled remainder
   always_comb begin
      s1_window  = s1_fast_ff ? udbn_pkg::DEADLINE_FAST_MS : udbn_pkg::DEADLINE_SLOW_MS;
      s2_prod_in = udbn_pkg::PROD_W'(s1_remain_ff) * udbn_pkg::PROD_W'(s1_total_ff);
      s2_wl_in   = udbn_pkg::PROD_W'(s1_window) * udbn_pkg::PROD_W'(s1_left_ff);
   end

   // stage 3: pace compare; strip the power of two from the deadline
   always_comb begin
      div_x = s2_fast_ff ? s2_prod_ff[udbn_pkg::PROD_W-1:3]
                         : {1'b0, s2_prod_ff[udbn_pkg::PROD_W-1:4]};
      s3_in.valid   = s2_valid_ff;
      s3_in.active  = s2_active_ff;
      s3_in.acc     = s2_acc_ff;
      s3_in.past    = s2_past_ff;
      s3_in.idle_gt = s2_idle_ff;
      s3_in.on_pace = s2_prod_ff >= s2_wl_ff;
      s3_in.left    = s2_left_ff;
   end

   udbn_div u_div (
      .clock  (clock),
      .enable (advance),
      .x      (div_x),
      .quot   (allow)
   );

   // stage 7: select the result
   always_comb begin
      if (!s6_ff.active) begin
         need_in = '0;
      end else if (s6_ff.past) begin
         need_in = s6_ff.left;
      end else if (s6_ff.on_pace) begin
         need_in = udbn_pkg::SIZE_W'(s6_ff.idle_gt);
      end else if (allow == '0) begin
         need_in = s6_ff.left;
      end else begin
         // allowance is below the remaining size here
         need_in = s6_ff.left - allow[udbn_pkg::SIZE_W-1:0] + udbn_pkg::SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         s4_ff.valid  <= 1'b0;
         s5_ff.valid  <= 1'b0;
         s6_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_ff.valid  <= s3_in.valid;
         s4_ff.valid  <= s3_ff.valid;
         s5_ff.valid  <= s4_ff.valid;
         s6_ff.valid  <= s5_ff.valid;
         out_valid_ff <= s6_ff.valid;

         s1_active_ff <= s1_active_in;
         s1_acc_ff    <= s1_acc_in;
         s1_fast_ff   <= s1_acc_in;
         s1_past_ff   <= s1_past_in;
         s1_idle_ff   <= s1_idle_in;
         s1_left_ff   <= s1_left_in;
         s1_total_ff  <= s1_total_in;
         s1_remain_ff <= s1_remain_in;

         s2_active_ff <= s1_active_ff;
         s2_acc_ff    <= s1_acc_ff;
         s2_fast_ff   <= s1_fast_ff;
         s2_past_ff   <= s1_past_ff;
         s2_idle_ff   <= s1_idle_ff;
         s2_left_ff   <= s1_left_ff;
         s2_prod_ff   <= s2_prod_in;
         s2_wl_ff     <= s2_wl_in;

         s3_ff.active  <= s3_in.active;
         s3_ff.acc     <= s3_in.acc;
         s3_ff.past    <= s3_in.past;
         s3_ff.idle_gt <= s3_in.idle_gt;
         s3_ff.on_pace <= s3_in.on_pace;
         s3_ff.left    <= s3_in.left;

         s4_ff.active  <= s3_ff.active;
         s4_ff.acc     <= s3_ff.acc;
         s4_ff.past    <= s3_ff.past;
         s4_ff.idle_gt <= s3_ff.idle_gt;
         s4_ff.on_pace <= s3_ff.on_pace;
         s4_ff.left    <= s3_ff.left;

         s5_ff.active  <= s4_ff.active;
         s5_ff.acc     <= s4_ff.acc;
         s5_ff.past    <= s4_ff.past;
         s5_ff.idle_gt <= s4_ff.idle_gt;
         s5_ff.on_pace <= s4_ff.on_pace;
         s5_ff.left    <= s4_ff.left;

         s6_ff.active  <= s5_ff.active;
         s6_ff.acc     <= s5_ff.acc;
         s6_ff.past    <= s5_ff.past;
         s6_ff.idle_gt <= s5_ff.idle_gt;
         s6_ff.on_pace <= s5_ff.on_pace;
         s6_ff.left    <= s5_ff.left;

         need_ff    <= need_in;
         acc_out_ff <= s6_ff.acc;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, acc_out_ff, need_ff};

endmodule

FILE: rtl/udbn_div.sv
// Four-stage pipelined divide by 5625 using a reciprocal multiply and one correction.
// Depends on udbn_pkg.
module udbn_div (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [udbn_pkg::DIVX_W-1:0]   x,
   output logic [udbn_pkg::QUOT_W-1:0]   quot
);

   logic [udbn_pkg::PP_W-1:0]   pp_lo_ff, pp_hi_ff;
   logic [udbn_pkg::PP_W-1:0]   pp_lo_in, pp_hi_in;
   logic [udbn_pkg::DIVX_W-1:0] xa_ff, xb_ff, xc_ff;
   logic [63:0]                 sum;
   logic [udbn_pkg::QUOT_W-1:0] qb_ff, qb_in, qc_ff, qd_ff, qd_in;
   logic [udbn_pkg::DIVX_W-1:0] prod_ff, prod_in, rem;

   always_comb begin
      pp_lo_in = udbn_pkg::PP_W'(x[udbn_pkg::SPLIT_W-1:0]) *
                 udbn_pkg::PP_W'(udbn_pkg::RECIP);
      pp_hi_in = udbn_pkg::PP_W'(x[udbn_pkg::DIVX_W-1:udbn_pkg::SPLIT_W]) *
                 udbn_pkg::PP_W'(udbn_pkg::RECIP);
      sum      = 64'(pp_lo_ff) + (64'(pp_hi_ff) << udbn_pkg::SPLIT_W);
      qb_in    = sum[63:udbn_pkg::RECIP_SHIFT];
      prod_in  = udbn_pkg::DIVX_W'(qb_ff) * udbn_pkg::DIVX_W'(udbn_pkg::DIV_BASE);
      rem      = xc_ff - prod_ff;
      // estimate is low by at most one
      qd_in    = qc_ff + udbn_pkg::QUOT_W'(rem >= udbn_pkg::DIVX_W'(udbn_pkg::DIV_BASE));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         xa_ff    <= x;
         qb_ff    <= qb_in;
         xb_ff    <= xa_ff;
         prod_ff  <= prod_in;
         qc_ff    <= qb_ff;
         xc_ff    <= xb_ff;
         qd_ff    <= qd_in;
      end
   end

   assign quot = qd_ff;

endmodule
